// File: rtl/core/bgip_pkg.sv
`default_nettype none

package bgip_pkg;

    // Table geometry.
    localparam int BRANCH_ENTRIES      = 128;
    localparam int BR_IW               = $clog2(BRANCH_ENTRIES);
    localparam int TRANSLATION_ENTRIES = 32;
    localparam int XL_IW               = $clog2(TRANSLATION_ENTRIES);
    localparam int FILTER_SLOTS        = 2048;
    localparam int FS_IW               = $clog2(FILTER_SLOTS);
    localparam int MAX_LOOKAHEAD       = 8;
    localparam int MAX_NEXTLINE        = 4;
    localparam int QDEPTH              = 2;
    localparam int Q_IW                = $clog2(QDEPTH);
    localparam int Q_CW                = $clog2(QDEPTH + 1);

    // Field widths.
    localparam int VB_W      = 42;
    localparam int PB_W      = 38;
    localparam int OFF_W     = 6;
    localparam int VPAGE_W   = VB_W - OFF_W;
    localparam int PPAGE_W   = PB_W - OFF_W;
    localparam int TAG_W     = 16;
    localparam int BTAG_LSB  = 17;
    localparam int FTAG_LSB  = 13;
    localparam int DELTA_W   = 8;
    localparam int CNT_W     = 4;
    localparam int DIFF_W    = VB_W + 2;

    // Multiplicative hash constant.
    localparam logic [63:0] GOLD = 64'h9E3779B97F4A7C15;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_PREFETCH = 2'd0,
        KIND_TGT_FILT = 2'd1,
        KIND_NL_FILT  = 2'd2,
        KIND_DONE     = 2'd3
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_FILTER_MODE     = 3'd0,
        CFG_LOOKAHEAD_DEPTH = 3'd1,
        CFG_NEXTLINE_COUNT  = 3'd2,
        CFG_CONFIDENCE_PCT  = 3'd3,
        CFG_DELTA_LIMIT     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic       filter_mode;
        logic [3:0] lookahead_depth;
        logic [2:0] nextline_count;
        logic [6:0] confidence_pct;
        logic [7:0] delta_limit;
    } t_cfg;

    // One queued input word.
    typedef struct packed {
        logic            op;
        logic [VB_W-1:0] vb;
        logic [PB_W-1:0] pb;
        logic [PB_W-1:0] ev;
    } t_item;

    // Branch table entry (the valid bit lives in flip-flops).
    typedef struct packed {
        logic [TAG_W-1:0]          tag;
        logic signed [DELTA_W-1:0] d0;
        logic signed [DELTA_W-1:0] d1;
        logic [CNT_W-1:0]          c0;
        logic [CNT_W-1:0]          c1;
        logic [FS_IW-1:0]          owned;
        logic                      has_owned;
    } t_bent;

    // Residency filter slot.
    typedef struct packed {
        logic             bit_set;
        logic [TAG_W-1:0] tag;
    } t_rent;

    // Two-delta saturating update of a branch entry.
    function automatic t_bent learn_update(t_bent e, logic signed [DELTA_W-1:0] d);
        t_bent                     r;
        logic signed [DELTA_W-1:0] td;
        logic [CNT_W-1:0]          tc;
        r = e;
        if (r.c0 != '0 && r.d0 == d) begin
            if (r.c0 != '1) r.c0 = r.c0 + 1'b1;
        end else if (r.c1 != '0 && r.d1 == d) begin
            if (r.c1 != '1) r.c1 = r.c1 + 1'b1;
        end else if (r.c0 == '0) begin
            r.d0 = d;
            r.c0 = CNT_W'(1);
        end else if (r.c1 == '0) begin
            r.d1 = d;
            r.c1 = CNT_W'(1);
        end else if (r.c0 <= r.c1) begin
            if (r.c0 == CNT_W'(1)) r.d0 = d;
            else r.c0 = r.c0 - 1'b1;
        end else begin
            if (r.c1 == CNT_W'(1)) r.d1 = d;
            else r.c1 = r.c1 - 1'b1;
        end
        if (r.c1 > r.c0) begin
            td   = r.d0;
            tc   = r.c0;
            r.d0 = r.d1;
            r.c0 = r.c1;
            r.d1 = td;
            r.c1 = tc;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/bgip_hash.sv
`default_nettype none

module bgip_hash
    import bgip_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_x,
    output logic             o_done,
    output logic [63:0]      o_h
);

    // Low 64 bits of x * GOLD from three 32x32 partial products, one per cycle.
    typedef enum logic [1:0] {H_IDLE, H_P0, H_P1, H_P2} t_hstate;

    t_hstate     r_state;
    logic [63:0] r_x;
    logic [63:0] r_lo;
    logic [31:0] r_hi;
    logic        r_done;
    logic [63:0] w_prod;
    logic [31:0] w_ma;
    logic [31:0] w_mb;

    // Operand selection for the shared multiplier.
    always_comb begin
        w_ma = r_x[31:0];
        w_mb = GOLD[31:0];
        case (r_state)
            H_P1:    begin w_ma = r_x[63:32]; w_mb = GOLD[31:0];  end
            H_P2:    begin w_ma = r_x[31:0];  w_mb = GOLD[63:32]; end
            default: begin w_ma = r_x[31:0];  w_mb = GOLD[31:0];  end
        endcase
        w_prod = {32'd0, w_ma} * {32'd0, w_mb};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_x;
                        r_state <= H_P0;
                    end
                end
                H_P0: begin
                    r_lo    <= w_prod;
                    r_state <= H_P1;
                end
                H_P1: begin
                    r_hi    <= w_prod[31:0];
                    r_state <= H_P2;
                end
                H_P2: begin
                    r_hi    <= r_hi + w_prod[31:0];
                    r_done  <= 1'b1;
                    r_state <= H_IDLE;
                end
                default: r_state <= H_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_h    = {r_lo[63:32] + r_hi, r_lo[31:0]};

endmodule

`default_nettype wire

// File: rtl/core/bgip_front.sv
`default_nettype none

module bgip_front
    import bgip_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic            i_op,
    input  wire logic [VB_W-1:0] i_virt_block,
    input  wire logic [PB_W-1:0] i_phys_block,
    input  wire logic [PB_W-1:0] i_evicted_block,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output t_item                o_head
);

    // Short queue of input words between the front and the back.
    t_item           r_q [QDEPTH];
    logic [Q_IW-1:0] r_wp;
    logic [Q_IW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;
    logic            w_push;
    logic            w_pop;
    t_item           w_item;

    // Classify: only the fields that the operation uses are kept.
    always_comb begin
        w_item    = '0;
        w_item.op = i_op;
        if (i_op) begin
            w_item.ev = i_evicted_block;
        end else begin
            w_item.vb = i_virt_block;
            w_item.pb = i_phys_block;
        end
    end

    assign busy    = (r_cnt == Q_CW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = start && !busy;
    assign w_pop   = i_pop && !o_empty;
    assign o_head  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_item;
                r_wp      <= (r_wp == Q_IW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == Q_IW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) r_cnt <= r_cnt + 1'b1;
            else if (!w_push && w_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bgip_back.sv
`default_nettype none

module bgip_back
    import bgip_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_empty,
    input  wire t_item       i_head,
    output logic             o_pop,
    output logic             o_valid,
    output logic [PB_W-1:0]  o_pf_block,
    output logic [1:0]       o_kind,
    output logic             o_is_last
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_EVH, S_XLH, S_LNH, S_LNR, S_LNU,
        S_WSTART, S_WPH, S_WPR, S_WPU, S_WXH, S_WRH, S_WRR, S_WRU, S_WNEXT,
        S_BSTART, S_BRH, S_BRR, S_BRU, S_BEMIT,
        S_GOH, S_GOR, S_GOU, S_GOC, S_DONE
    } t_state;

    t_state r_state;
    t_item  r_item;

    // Hash unit.
    logic        r_hs;
    logic [63:0] r_hx;
    logic        w_hdone;
    logic [63:0] w_h;

    bgip_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_hs),
        .i_x     (r_hx),
        .o_done  (w_hdone),
        .o_h     (w_h)
    );

    // Branch table memory with valid bits in flip-flops.
    t_bent              r_bmem [BRANCH_ENTRIES];
    logic               r_bval [BRANCH_ENTRIES];
    logic [BR_IW-1:0]   r_bi;
    logic [TAG_W-1:0]   r_btag;
    t_bent              r_brd;
    logic               r_bwe;
    t_bent              r_bwdata;

    // Translation cache.
    logic               r_xval [TRANSLATION_ENTRIES];
    logic [VPAGE_W-1:0] r_xvp  [TRANSLATION_ENTRIES];
    logic [PPAGE_W-1:0] r_xpp  [TRANSLATION_ENTRIES];

    // Residency filter memory.
    t_rent              r_rmem [FILTER_SLOTS];
    logic [FS_IW-1:0]   r_slot;
    logic [TAG_W-1:0]   r_ftag;
    t_rent              r_rrd;
    logic               r_rwe;
    logic [FS_IW-1:0]   r_rwaddr;
    t_rent              r_rwdata;
    logic [FS_IW-1:0]   r_cidx;
    logic [FS_IW-1:0]   r_clrx;

    // Fetch history and walk state.
    logic [VB_W-1:0]    r_last;
    logic               r_have_prev;
    logic [63:0]        r_cur;
    logic [63:0]        r_nx;
    logic [3:0]         r_step;
    logic [PB_W-1:0]    r_pb;
    logic [2:0]         r_k;
    logic               r_ret_walk;

    // Registered result port.
    logic               r_ov;
    logic [PB_W-1:0]    r_opb;
    t_kind              r_okind;
    logic               r_olast;

    // Combinational helpers.
    logic                      w_bval;
    logic                      w_bmatch;
    logic                      w_hit;
    t_bent                     w_claim;
    t_bent                     w_gown;
    logic [63:0]               w_nx;
    logic                      w_brk;
    logic [10:0]               w_c0x100;
    logic [11:0]               w_pct_t;
    logic [3:0]                w_depth;
    logic [2:0]                w_burst;
    logic [OFF_W-1:0]          w_off;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [DIFF_W-1:0]  w_lim;
    logic                      w_learn;
    logic [XL_IW-1:0]          w_xi;
    logic                      w_xhit;
    logic                      w_rtest;
    t_rent                     w_rbase;
    t_rent                     w_rset;
    logic                      w_goclr;
    logic                      w_bstop;

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        // Branch entry lookup against the current tag.
        w_bval   = r_bval[r_bi];
        w_bmatch = w_bval && (r_brd.tag == r_btag);
        w_hit    = w_bmatch && (r_brd.c0 != '0);
        w_claim     = '0;
        w_claim.tag = r_btag;
        if (w_bmatch) w_claim = r_brd;

        // Entry as it stands once it owns the current slot.
        w_gown           = w_claim;
        w_gown.owned     = r_slot;
        w_gown.has_owned = 1'b1;

        // Next target and confidence stop.
        w_c0x100 = 11'(r_brd.c0) * 11'd100;
        w_pct_t  = 12'(i_cfg.confidence_pct) * 12'({1'b0, r_brd.c0} + {1'b0, r_brd.c1});
        if (w_hit) begin
            w_nx  = r_cur + {{(64-DELTA_W){r_brd.d0[DELTA_W-1]}}, r_brd.d0};
            w_brk = (r_step != '0) && (12'(w_c0x100) < w_pct_t);
        end else begin
            w_nx  = r_cur + 64'd1;
            w_brk = (r_step != '0) && (i_cfg.confidence_pct != '0);
        end

        // Saturated counts.
        w_depth = (i_cfg.lookahead_depth > 4'(MAX_LOOKAHEAD)) ?
                  4'(MAX_LOOKAHEAD) : i_cfg.lookahead_depth;
        w_burst = (i_cfg.nextline_count > 3'(MAX_NEXTLINE)) ?
                  3'(MAX_NEXTLINE) : i_cfg.nextline_count;
        w_off   = r_item.pb[OFF_W-1:0];
        w_bstop = (r_k == w_burst) ||
                  ((7'(w_off) + 7'(r_k)) == 7'd63);

        // Learned delta and its range check.
        w_diff  = $signed({2'b00, r_item.vb}) - $signed({2'b00, r_last});
        w_lim   = (i_cfg.delta_limit > 8'd128) ? DIFF_W'(128) : DIFF_W'(i_cfg.delta_limit);
        w_learn = r_have_prev && (w_diff < w_lim) && (w_diff > -w_lim);

        // Translation lookup of the next target.
        w_xi   = w_h[XL_IW-1:0];
        w_xhit = r_xval[w_xi] && (r_nx[63:VB_W] == '0) &&
                 (r_xvp[w_xi] == r_nx[VB_W-1:OFF_W]);

        // Residency test.
        w_rtest = i_cfg.filter_mode ? (r_rrd.tag == r_ftag) : r_rrd.bit_set;

        // Slot handover: a replaced entry that owned this slot clears it first.
        w_rbase = (!w_bmatch && w_bval && r_brd.has_owned && (r_brd.owned == r_slot)) ?
                  '0 : r_rrd;
        w_rset  = w_rbase;
        if (i_cfg.filter_mode) w_rset.tag = r_ftag;
        else w_rset.bit_set = 1'b1;
        w_goclr = w_bval && r_brd.has_owned && (r_brd.owned != r_slot);
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cidx      <= '0;
            r_hs        <= 1'b0;
            r_bwe       <= 1'b0;
            r_rwe       <= 1'b0;
            r_ov        <= 1'b0;
            r_have_prev <= 1'b0;
            r_last      <= '0;
            for (int i = 0; i < BRANCH_ENTRIES; i++) r_bval[i] <= 1'b0;
            for (int i = 0; i < TRANSLATION_ENTRIES; i++) r_xval[i] <= 1'b0;
        end else begin
            r_hs  <= 1'b0;
            r_bwe <= 1'b0;
            r_rwe <= 1'b0;
            r_ov  <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_rwe    <= 1'b1;
                    r_rwaddr <= r_cidx;
                    r_rwdata <= '0;
                    r_cidx   <= r_cidx + 1'b1;
                    if (r_cidx == '1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_item <= i_head;
                        r_hs   <= 1'b1;
                        if (i_head.op) begin
                            r_hx    <= 64'(i_head.ev);
                            r_state <= S_EVH;
                        end else begin
                            r_hx    <= 64'(i_head.vb[VB_W-1:OFF_W]);
                            r_state <= S_XLH;
                        end
                    end
                end
                S_EVH: begin
                    if (w_hdone) begin
                        r_rwe    <= 1'b1;
                        r_rwaddr <= w_h[FS_IW-1:0];
                        r_rwdata <= '0;
                        r_state  <= S_DONE;
                    end
                end
                S_XLH: begin
                    if (w_hdone) begin
                        r_xval[w_xi] <= 1'b1;
                        r_xvp[w_xi]  <= r_item.vb[VB_W-1:OFF_W];
                        r_xpp[w_xi]  <= r_item.pb[PB_W-1:OFF_W];
                        if (w_learn) begin
                            r_hs    <= 1'b1;
                            r_hx    <= 64'(r_last);
                            r_state <= S_LNH;
                        end else begin
                            r_state <= S_WSTART;
                        end
                    end
                end
                S_LNH: begin
                    if (w_hdone) begin
                        r_bi    <= w_h[BR_IW-1:0];
                        r_btag  <= w_h[BTAG_LSB +: TAG_W];
                        r_state <= S_LNR;
                    end
                end
                S_LNR: r_state <= S_LNU;
                S_LNU: begin
                    if (!w_bmatch && w_bval && r_brd.has_owned) begin
                        r_rwe    <= 1'b1;
                        r_rwaddr <= r_brd.owned;
                        r_rwdata <= '0;
                    end
                    r_bwe        <= 1'b1;
                    r_bwdata     <= learn_update(w_claim, w_diff[DELTA_W-1:0]);
                    r_bval[r_bi] <= 1'b1;
                    r_state      <= S_WSTART;
                end
                S_WSTART: begin
                    r_step <= '0;
                    r_cur  <= 64'(r_item.vb);
                    if (w_depth == '0) begin
                        r_state <= S_BSTART;
                    end else begin
                        r_hs    <= 1'b1;
                        r_hx    <= 64'(r_item.vb);
                        r_state <= S_WPH;
                    end
                end
                S_WPH: begin
                    if (w_hdone) begin
                        r_bi    <= w_h[BR_IW-1:0];
                        r_btag  <= w_h[BTAG_LSB +: TAG_W];
                        r_state <= S_WPR;
                    end
                end
                S_WPR: r_state <= S_WPU;
                S_WPU: begin
                    if (w_brk) begin
                        r_state <= S_BSTART;
                    end else begin
                        r_nx    <= w_nx;
                        r_hs    <= 1'b1;
                        r_hx    <= {6'd0, w_nx[63:OFF_W]};
                        r_state <= S_WXH;
                    end
                end
                S_WXH: begin
                    if (w_hdone) begin
                        if (w_xhit) begin
                            r_pb    <= {r_xpp[w_xi], r_nx[OFF_W-1:0]};
                            r_hs    <= 1'b1;
                            r_hx    <= 64'({r_xpp[w_xi], r_nx[OFF_W-1:0]});
                            r_state <= S_WRH;
                        end else begin
                            r_state <= S_WNEXT;
                        end
                    end
                end
                S_WRH: begin
                    if (w_hdone) begin
                        r_slot  <= w_h[FS_IW-1:0];
                        r_ftag  <= w_h[FTAG_LSB +: TAG_W];
                        r_state <= S_WRR;
                    end
                end
                S_WRR: r_state <= S_WRU;
                S_WRU: begin
                    r_ov    <= 1'b1;
                    r_opb   <= r_pb;
                    r_olast <= 1'b0;
                    if (w_rtest) begin
                        r_okind <= KIND_TGT_FILT;
                        r_state <= S_WNEXT;
                    end else begin
                        r_okind    <= KIND_PREFETCH;
                        r_ret_walk <= 1'b1;
                        r_hs       <= 1'b1;
                        r_hx       <= r_nx;
                        r_state    <= S_GOH;
                    end
                end
                S_WNEXT: begin
                    r_cur <= r_nx;
                    if (r_step + 4'd1 == w_depth) begin
                        r_state <= S_BSTART;
                    end else begin
                        r_step  <= r_step + 4'd1;
                        r_hs    <= 1'b1;
                        r_hx    <= r_nx;
                        r_state <= S_WPH;
                    end
                end
                S_BSTART: begin
                    r_k <= 3'd1;
                    if (w_burst != '0 && w_off != '1) begin
                        r_pb    <= r_item.pb + PB_W'(1);
                        r_hs    <= 1'b1;
                        r_hx    <= 64'(r_item.pb + PB_W'(1));
                        r_state <= S_BRH;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_BRH: begin
                    if (w_hdone) begin
                        r_slot  <= w_h[FS_IW-1:0];
                        r_ftag  <= w_h[FTAG_LSB +: TAG_W];
                        r_state <= S_BRR;
                    end
                end
                S_BRR: r_state <= S_BRU;
                S_BRU: begin
                    if (w_rtest) begin
                        r_ov    <= 1'b1;
                        r_opb   <= r_pb;
                        r_okind <= KIND_NL_FILT;
                        r_olast <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_BEMIT;
                    end
                end
                S_BEMIT: begin
                    r_ov    <= 1'b1;
                    r_opb   <= r_item.pb + PB_W'(r_k);
                    r_okind <= KIND_PREFETCH;
                    r_olast <= 1'b0;
                    r_k     <= r_k + 3'd1;
                    if (w_bstop) begin
                        r_ret_walk <= 1'b0;
                        r_hs       <= 1'b1;
                        r_hx       <= 64'(r_item.vb);
                        r_state    <= S_GOH;
                    end
                end
                S_GOH: begin
                    if (w_hdone) begin
                        r_bi    <= w_h[BR_IW-1:0];
                        r_btag  <= w_h[BTAG_LSB +: TAG_W];
                        r_state <= S_GOR;
                    end
                end
                S_GOR: r_state <= S_GOU;
                S_GOU: begin
                    r_rwe        <= 1'b1;
                    r_rwaddr     <= r_slot;
                    r_rwdata     <= w_rset;
                    r_clrx       <= r_brd.owned;
                    r_bwe        <= 1'b1;
                    r_bwdata     <= w_gown;
                    r_bval[r_bi] <= 1'b1;
                    if (w_goclr) r_state <= S_GOC;
                    else if (r_ret_walk) r_state <= S_WNEXT;
                    else r_state <= S_DONE;
                end
                S_GOC: begin
                    r_rwe    <= 1'b1;
                    r_rwaddr <= r_clrx;
                    r_rwdata <= '0;
                    r_state  <= r_ret_walk ? S_WNEXT : S_DONE;
                end
                S_DONE: begin
                    r_ov    <= 1'b1;
                    r_opb   <= '0;
                    r_okind <= KIND_DONE;
                    r_olast <= 1'b1;
                    if (!r_item.op) begin
                        r_last      <= r_item.vb;
                        r_have_prev <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Branch table port: one write, one registered read.
    always_ff @(posedge i_clk) begin
        if (r_bwe) r_bmem[r_bi] <= r_bwdata;
        r_brd <= r_bmem[r_bi];
    end

    // Residency port: one write, one registered read.
    always_ff @(posedge i_clk) begin
        if (r_rwe) r_rmem[r_rwaddr] <= r_rwdata;
        r_rrd <= r_rmem[r_slot];
    end

    assign o_valid    = r_ov;
    assign o_pf_block = r_opb;
    assign o_kind     = r_okind;
    assign o_is_last  = r_olast;

endmodule

`default_nettype wire

// File: rtl/core/branch_graph_instr_prefetcher_top.sv
`default_nettype none

// Instruction prefetcher driven by fetch and L2 eviction words.
// Input: a word (i_op, i_virt_block, i_phys_block, i_evicted_block) is taken
// at a rising edge where start is high and busy is low. A two-word queue sits
// in front of the sequencer, so busy only rises when both places are full.
// Output: each result is shown for one cycle with o_valid high; the receiver
// cannot hold it off. Every word ends with a done result (o_is_last high).
// Work: every hash runs on one shared 32x32 multiplier, and each memory lookup
// adds a registered read. An eviction clears one filter slot. A fetch does its
// fixed work, may learn a delta, walks up to eight predicted targets (each one
// stops the walk, does not translate, is filtered or is issued), then runs the
// next-line burst.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_addr at once;
// write only while no word is in flight.
// Reset: synchronous, active low. After reset the 2048 residency filter slots
// are swept clear; words are queued meanwhile but not started.
module branch_graph_instr_prefetcher_top
    import bgip_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic            i_op,
    input  wire logic [VB_W-1:0] i_virt_block,
    input  wire logic [PB_W-1:0] i_phys_block,
    input  wire logic [PB_W-1:0] i_evicted_block,
    input  wire logic            i_cfg_we,
    input  wire logic [2:0]      i_cfg_addr,
    input  wire logic [7:0]      i_cfg_wdata,
    output logic                 o_valid,
    output logic [PB_W-1:0]      o_pf_block,
    output logic [1:0]           o_kind,
    output logic                 o_is_last
);

    t_cfg  r_cfg;
    t_item w_head;
    logic  w_empty;
    logic  w_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_mode     <= 1'b0;
            r_cfg.lookahead_depth <= 4'd8;
            r_cfg.nextline_count  <= 3'd2;
            r_cfg.confidence_pct  <= 7'd60;
            r_cfg.delta_limit     <= 8'd128;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FILTER_MODE:     r_cfg.filter_mode     <= i_cfg_wdata[0];
                CFG_LOOKAHEAD_DEPTH: r_cfg.lookahead_depth <= i_cfg_wdata[3:0];
                CFG_NEXTLINE_COUNT:  r_cfg.nextline_count  <= i_cfg_wdata[2:0];
                CFG_CONFIDENCE_PCT:  r_cfg.confidence_pct  <= i_cfg_wdata[6:0];
                CFG_DELTA_LIMIT:     r_cfg.delta_limit     <= i_cfg_wdata;
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    bgip_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_virt_block    (i_virt_block),
        .i_phys_block    (i_phys_block),
        .i_evicted_block (i_evicted_block),
        .i_pop           (w_pop),
        .o_empty         (w_empty),
        .o_head          (w_head)
    );

    bgip_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_empty    (w_empty),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .o_pf_block (o_pf_block),
        .o_kind     (o_kind),
        .o_is_last  (o_is_last)
    );

endmodule

`default_nettype wire
